/* sv/wfc_pkg.sv */
// Package for the wall-follow turn controller: shared types, mode and
// action codes, register indexes and step lengths. No dependencies.
`timescale 1ns / 1ps

package wfc_pkg;

    // Step lengths of the timed turn drives, in milliseconds
    localparam logic [15:0] TURN_STEP_MS = 16'd50;
    localparam logic [15:0] BACK_STEP_MS = 16'd50;
    localparam logic [15:0] LOST_STEP_MS = 16'd50;

    // Modes
    localparam logic [1:0] MODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;
    localparam logic [1:0] MODE_BACK  = 2'd3;

    // Motor actions
    localparam logic [2:0] ACT_STOP  = 3'd0;
    localparam logic [2:0] ACT_FAST  = 3'd1;
    localparam logic [2:0] ACT_SLOW  = 3'd2;
    localparam logic [2:0] ACT_LOST  = 3'd3;
    localparam logic [2:0] ACT_LEFT  = 3'd4;
    localparam logic [2:0] ACT_RIGHT = 3'd5;
    localparam logic [2:0] ACT_SPIN  = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_FRONT_SAFE = 3'd0;
    localparam logic [2:0] REG_FRONT_SLOW = 3'd1;
    localparam logic [2:0] REG_BACK_CLEAR = 3'd2;
    localparam logic [2:0] REG_TURN_MIN   = 3'd3;
    localparam logic [2:0] REG_TURN_MAX   = 3'd4;
    localparam logic [2:0] REG_BACK_MIN   = 3'd5;
    localparam logic [2:0] REG_BACK_MAX   = 3'd6;
    localparam logic [2:0] REG_CONFIRM    = 3'd7;

    typedef struct packed {
        logic [8:0]  front_safe_cm;
        logic [8:0]  front_slow_cm;
        logic [8:0]  back_clear_cm;
        logic [15:0] turn_min_ms;
        logic [15:0] turn_max_ms;
        logic [15:0] back_min_ms;
        logic [15:0] back_max_ms;
        logic [3:0]  confirm_needed;
    } t_cfg;

    typedef struct packed {
        logic       right_wall;
        logic       left_wall;
        logic       front_ok;
        logic [8:0] front_distance;
    } t_sensor;

    typedef struct packed {
        logic        sensor_fault;
        logic [1:0]  mode_after;
        logic [15:0] drive_ms;
        logic [2:0]  motor_action;
    } t_result;

endpackage

/* sv/wfc_cfg_regs.sv */
// Configuration register file of the wall-follow turn controller.
// Depends on wfc_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module wfc_cfg_regs import wfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRONT_SAFE: n_cfg.front_safe_cm  = i_cfg_wdata[8:0];
                REG_FRONT_SLOW: n_cfg.front_slow_cm  = i_cfg_wdata[8:0];
                REG_BACK_CLEAR: n_cfg.back_clear_cm  = i_cfg_wdata[8:0];
                REG_TURN_MIN:   n_cfg.turn_min_ms    = i_cfg_wdata;
                REG_TURN_MAX:   n_cfg.turn_max_ms    = i_cfg_wdata;
                REG_BACK_MIN:   n_cfg.back_min_ms    = i_cfg_wdata;
                REG_BACK_MAX:   n_cfg.back_max_ms    = i_cfg_wdata;
                REG_CONFIRM:    n_cfg.confirm_needed = i_cfg_wdata[3:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // Registers with their reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_safe_cm  <= 9'd20;
            r_cfg.front_slow_cm  <= 9'd30;
            r_cfg.back_clear_cm  <= 9'd25;
            r_cfg.turn_min_ms    <= 16'd200;
            r_cfg.turn_max_ms    <= 16'd1500;
            r_cfg.back_min_ms    <= 16'd400;
            r_cfg.back_max_ms    <= 16'd2500;
            r_cfg.confirm_needed <= 4'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/wfc_core.sv */
// Decision logic and mode state of the wall-follow turn controller.
// Depends on wfc_pkg for the codes, step lengths and structs.
`timescale 1ns / 1ps

module wfc_core import wfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_sensor i_sens,
    output t_result o_res
);

    logic [1:0]  r_mode,        n_mode;
    logic [15:0] r_mode_time,   n_mode_time;
    logic [3:0]  r_confirm_run, n_confirm_run;

    logic        front_safe_fwd;
    logic        front_safe_back;
    logic        side_wall;
    logic        turn_back;
    logic        cond;
    logic [3:0]  run_upd;
    logic        confirmed;
    logic [15:0] min_ms;
    logic [15:0] max_ms;
    logic        reached_min;
    logic        reached_max;
    logic        finish;
    logic        lost;
    logic [15:0] step_ms;
    logic [15:0] remain;
    logic [15:0] drive;
    t_result     res;

    // Threshold compares and wall selection used by the mode logic
    assign front_safe_fwd  = i_sens.front_ok && (i_sens.front_distance > i_cfg.front_safe_cm);
    assign front_safe_back = i_sens.front_ok && (i_sens.front_distance > i_cfg.back_clear_cm);
    assign side_wall       = (r_mode == MODE_LEFT) ? i_sens.left_wall : i_sens.right_wall;
    assign turn_back       = (r_mode == MODE_BACK);

    // Finish condition and its saturating confirm run
    assign cond      = turn_back ? front_safe_back : side_wall;
    assign run_upd   = !cond ? 4'd0 :
                       (r_confirm_run < i_cfg.confirm_needed) ? r_confirm_run + 4'd1 :
                       r_confirm_run;
    assign confirmed = (run_upd >= i_cfg.confirm_needed);

    // Limits of the current turn mode
    assign min_ms      = turn_back ? i_cfg.back_min_ms : i_cfg.turn_min_ms;
    assign max_ms      = turn_back ? i_cfg.back_max_ms : i_cfg.turn_max_ms;
    assign reached_min = (r_mode_time >= min_ms);
    assign reached_max = (r_mode_time >= max_ms);
    assign finish      = (reached_min && confirmed) || reached_max;

    // Step length, cut to the time left before the maximum
    assign lost    = !turn_back && !i_sens.left_wall && !i_sens.right_wall && front_safe_fwd;
    assign step_ms = turn_back ? BACK_STEP_MS : (lost ? LOST_STEP_MS : TURN_STEP_MS);
    assign remain  = reached_max ? 16'd0 : (max_ms - r_mode_time);
    assign drive   = (remain > step_ms) ? step_ms : remain;

    // Next state and result
    always_comb begin
        n_mode        = r_mode;
        n_mode_time   = r_mode_time;
        n_confirm_run = r_confirm_run;
        res.motor_action = ACT_STOP;
        res.drive_ms     = 16'd0;
        res.sensor_fault = 1'b0;
        case (r_mode)
            MODE_FWD: begin
                if (!i_sens.front_ok) begin
                    res.sensor_fault = 1'b1;
                end else if (!i_sens.left_wall) begin
                    n_mode        = MODE_LEFT;
                    n_mode_time   = 16'd0;
                    n_confirm_run = 4'd0;
                end else if (front_safe_fwd) begin
                    res.motor_action = (i_sens.front_distance < i_cfg.front_slow_cm) ?
                                       ACT_SLOW : ACT_FAST;
                end else if (!i_sens.right_wall) begin
                    n_mode        = MODE_RIGHT;
                    n_mode_time   = 16'd0;
                    n_confirm_run = 4'd0;
                end else begin
                    n_mode        = MODE_BACK;
                    n_mode_time   = 16'd0;
                    n_confirm_run = 4'd0;
                end
            end
            default: begin
                // The run only moves once the minimum time has been reached
                if (reached_min) begin
                    n_confirm_run = run_upd;
                end
                if (finish) begin
                    n_mode        = MODE_FWD;
                    n_mode_time   = 16'd0;
                    n_confirm_run = 4'd0;
                end else begin
                    res.drive_ms = drive;
                    n_mode_time  = r_mode_time + drive;
                    if (turn_back) begin
                        res.motor_action = ACT_SPIN;
                    end else if (lost) begin
                        res.motor_action = ACT_LOST;
                    end else if (r_mode == MODE_LEFT) begin
                        res.motor_action = ACT_LEFT;
                    end else begin
                        res.motor_action = ACT_RIGHT;
                    end
                end
            end
        endcase
        res.mode_after = n_mode;
    end

    // State advances once per reading passed on to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_FWD;
            r_mode_time   <= 16'd0;
            r_confirm_run <= 4'd0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_mode_time   <= n_mode_time;
            r_confirm_run <= n_confirm_run;
        end
    end

    assign o_res = res;

    // Forward mode always holds a cleared timer and run
    a_fwd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_FWD |-> r_mode_time == 16'd0 && r_confirm_run == 4'd0)
        else $error("forward mode with live turn state");

    // A timed drive adds exactly its length to the mode timer
    a_time_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.drive_ms != 16'd0 |=>
        r_mode_time == $past(r_mode_time) + $past(res.drive_ms))
        else $error("mode timer did not follow drive time");

    // A sensor fault leaves the mode untouched
    a_fault_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.sensor_fault |=> $stable(r_mode) && $stable(r_mode_time))
        else $error("state moved on a sensor fault");

endmodule

/* sv/wall_follow_turn_controller.sv */
// Top level of the wall-follow turn controller: input and result registers
// around wfc_core, plus the wfc_cfg_regs register file. Uses wfc_pkg.
//
// Usage: each slave-side beat carries one sensor reading; each master-side
// beat carries the motor command it causes (exactly one per reading).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata,
// one register per cycle; the user must write only while no reading is
// in flight, as the block itself does not enforce this. A reading waits
// in the input register until the result register is free, is then decided
// and loaded into the result register, and its command is on m_axis.
// Throughput: one reading per cycle while the result can move on. The mode
// state is updated as each reading is decided, so readings go back to back.
// Stall: when m_axis_tready is low the result holds, the input register
// still takes one more beat, and s_axis_tready drops only once both
// registers are full.
// Reset: synchronous, active low; clears both stages, the mode (forward),
// mode timer and confirm run, and loads the register reset values.
`timescale 1ns / 1ps

module wall_follow_turn_controller import wfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sensor reading beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] front_distance, [9] front_ok, [10] left_wall, [11] right_wall,
    // [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // Motor command beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] motor_action, [18:3] drive_ms, [20:19] mode_after,
    // [21] sensor_fault, [23:22] zero
    output logic [23:0] m_axis_tdata,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result core_res;
    t_sensor r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;
    logic    in_take;

    wfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Handshake between the two stages
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    wfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_sens  (r_in),
        .o_res   (core_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= s_axis_tdata[11:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    // A stop never carries a drive time
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.motor_action == ACT_STOP |-> r_out.drive_ms == 16'd0)
        else $error("stop command with non-zero drive time");

    // A fault is only raised by a stop in forward mode
    a_fault_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sensor_fault |->
        r_out.motor_action == ACT_STOP && r_out.mode_after == MODE_FWD)
        else $error("sensor fault outside a forward stop");

    // A reading waiting in the input register moves on as soon as the output frees
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_free && !in_take |=> r_out_valid && !r_in_valid)
        else $error("input stage failed to advance");

endmodule

/* sim/wfc_checker.sv */
// Checker for the wall-follow turn controller: watches both stream channels and the
// configuration port, predicts each motor command and compares it. Uses wfc_pkg.
`timescale 1ns / 1ps

module wfc_checker import wfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [8:0] front_distance, [9] front_ok, [10] left_wall, [11] right_wall
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] motor_action, [18:3] drive_ms, [20:19] mode_after, [21] sensor_fault
    input  logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copy of the registers and of the navigation state.
    t_cfg        cfg;
    logic [1:0]  mode;
    logic [15:0] mode_time;
    logic [3:0]  confirm_run;
    t_result     expected_commands[$];

    // Counts consecutive finish readings, saturating at the needed count.
    function automatic logic count_confirm(input logic cond);
        if (cond) begin
            if (confirm_run < cfg.confirm_needed)
                confirm_run = confirm_run + 4'd1;
        end else begin
            confirm_run = 4'd0;
        end
        return confirm_run >= cfg.confirm_needed;
    endfunction

    // A timed step never runs past the forced end time.
    function automatic logic [15:0] bounded_step(input logic [15:0] max_ms,
                                                 input logic [15:0] step_ms);
        logic [15:0] remain;
        remain = (mode_time < max_ms) ? max_ms - mode_time : 16'd0;
        return (remain > step_ms) ? step_ms : remain;
    endfunction

    function automatic logic is_clear(input t_sensor rd, input logic [8:0] thr);
        return rd.front_ok && (rd.front_distance > thr);
    endfunction

    function automatic void start_mode(input logic [1:0] next_mode);
        mode        = next_mode;
        mode_time   = 16'd0;
        confirm_run = 4'd0;
    endfunction

    // Works out the motor command for one reading and advances the state.
    function automatic t_result predict_command(input t_sensor rd);
        t_result res;
        logic    finish;
        logic    side;
        res    = '0;
        finish = 1'b0;
        case (mode)
            MODE_FWD: begin
                if (!rd.front_ok)
                    res.sensor_fault = 1'b1;
                else if (!rd.left_wall)
                    start_mode(MODE_LEFT);
                else if (is_clear(rd, cfg.front_safe_cm))
                    res.motor_action = (rd.front_distance < cfg.front_slow_cm) ?
                                       ACT_SLOW : ACT_FAST;
                else if (!rd.right_wall)
                    start_mode(MODE_RIGHT);
                else
                    start_mode(MODE_BACK);
            end
            MODE_BACK: begin
                if (mode_time >= cfg.back_min_ms)
                    finish = count_confirm(is_clear(rd, cfg.back_clear_cm));
                if (mode_time >= cfg.back_max_ms)
                    finish = 1'b1;
                if (finish) begin
                    start_mode(MODE_FWD);
                end else begin
                    res.drive_ms     = bounded_step(cfg.back_max_ms, BACK_STEP_MS);
                    res.motor_action = ACT_SPIN;
                    mode_time        = mode_time + res.drive_ms;
                end
            end
            default: begin
                side = (mode == MODE_LEFT) ? rd.left_wall : rd.right_wall;
                if (mode_time >= cfg.turn_min_ms)
                    finish = count_confirm(side);
                if (mode_time >= cfg.turn_max_ms)
                    finish = 1'b1;
                if (finish) begin
                    start_mode(MODE_FWD);
                end else if (!rd.left_wall && !rd.right_wall &&
                             is_clear(rd, cfg.front_safe_cm)) begin
                    // Both sides open: creep forward instead of turning.
                    res.drive_ms     = bounded_step(cfg.turn_max_ms, LOST_STEP_MS);
                    res.motor_action = ACT_LOST;
                    mode_time        = mode_time + res.drive_ms;
                end else begin
                    res.drive_ms     = bounded_step(cfg.turn_max_ms, TURN_STEP_MS);
                    res.motor_action = (mode == MODE_LEFT) ? ACT_LEFT : ACT_RIGHT;
                    mode_time        = mode_time + res.drive_ms;
                end
            end
        endcase
        res.mode_after = mode;
        return res;
    endfunction

    // Result beats are checked before new readings are predicted, so a beat can
    // never be matched against a reading taken at the same edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.front_safe_cm  = 9'd20;
            cfg.front_slow_cm  = 9'd30;
            cfg.back_clear_cm  = 9'd25;
            cfg.turn_min_ms    = 16'd200;
            cfg.turn_max_ms    = 16'd1500;
            cfg.back_min_ms    = 16'd400;
            cfg.back_max_ms    = 16'd2500;
            cfg.confirm_needed = 4'd3;
            mode               = MODE_FWD;
            mode_time          = 16'd0;
            confirm_run        = 4'd0;
            expected_commands.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[21:0]);
                if (expected_commands.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected beat: act %0d drive %0d mode %0d fault %0d",
                                 $realtime, got.motor_action, got.drive_ms,
                                 got.mode_after, got.sensor_fault);
                end else begin
                    want = expected_commands.pop_front();
                    if (got.motor_action != want.motor_action ||
                        got.drive_ms != want.drive_ms ||
                        got.mode_after != want.mode_after ||
                        got.sensor_fault != want.sensor_fault ||
                        m_axis_tdata[23:22] != 2'b00) begin
                        o_fail_count++;
                        // Fields in the order act/drive/mode/fault.
                        if (o_fail_count <= 10)
                            $display("%0t: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad %0d",
                                     $realtime, want.motor_action, want.drive_ms,
                                     want.mode_after, want.sensor_fault,
                                     got.motor_action, got.drive_ms, got.mode_after,
                                     got.sensor_fault, m_axis_tdata[23:22]);
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRONT_SAFE: cfg.front_safe_cm  = i_cfg_wdata[8:0];
                    REG_FRONT_SLOW: cfg.front_slow_cm  = i_cfg_wdata[8:0];
                    REG_BACK_CLEAR: cfg.back_clear_cm  = i_cfg_wdata[8:0];
                    REG_TURN_MIN:   cfg.turn_min_ms    = i_cfg_wdata;
                    REG_TURN_MAX:   cfg.turn_max_ms    = i_cfg_wdata;
                    REG_BACK_MIN:   cfg.back_min_ms    = i_cfg_wdata;
                    REG_BACK_MAX:   cfg.back_max_ms    = i_cfg_wdata;
                    REG_CONFIRM:    cfg.confirm_needed = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_commands.push_back(predict_command(t_sensor'(s_axis_tdata[11:0])));
        end
        o_pending = expected_commands.size();
    end

endmodule

/* sim/wall_follow_turn_controller_test.sv */
// Testbench top for the wall-follow turn controller: drives sensor readings, the
// receiver's ready and register writes, and gives the verdict. Needs wfc_pkg and wfc_checker.
`timescale 1ns / 1ps

module wall_follow_turn_controller_test import wfc_pkg::*;;

    localparam int CYCLE_LIMIT = 100000;

    typedef enum int {
        EP_CORRIDOR,
        EP_LEFT_OPENING,
        EP_RIGHT_OPENING,
        EP_DEAD_END,
        EP_OPEN_FIELD,
        EP_NOISE
    } t_episode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [8:0] front_distance, [9] front_ok, [10] left_wall, [11] right_wall
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] motor_action, [18:3] drive_ms, [20:19] mode_after, [21] sensor_fault
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          tx_idle_pct = 12;
    int          rx_idle_pct = 73;
    bit          stall_rx = 1'b0;
    // Thresholds in force, used to aim distances at the decision points.
    logic [8:0]  aim_safe = 9'd20;
    logic [8:0]  aim_slow = 9'd30;
    logic [8:0]  aim_clear = 9'd25;

    wall_follow_turn_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    wfc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random ready, held low entirely during a pressure stretch.
    always @(negedge i_clk)
        m_axis_tready <= !stall_rx && ($urandom_range(99) >= rx_idle_pct);

    function automatic logic [8:0] close_to(input logic [8:0] thr);
        int v;
        v = int'(thr) + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        else if (v > 511)
            v = 511;
        return v[8:0];
    endfunction

    function automatic logic [8:0] beyond(input logic [8:0] thr);
        if (thr == 9'd511)
            return 9'd511;
        return 9'($urandom_range(511, int'(thr) + 1));
    endfunction

    function automatic logic [8:0] short_of(input logic [8:0] thr);
        return 9'($urandom_range(int'(thr), 0));
    endfunction

    // Offers one reading beat, after random idle cycles, and waits for acceptance.
    task automatic send_reading(input logic [8:0] reach, input logic ok,
                                input logic lw, input logic rw);
        t_sensor rd;
        rd.front_distance = reach;
        rd.front_ok       = ok;
        rd.left_wall      = lw;
        rd.right_wall     = rw;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, rd};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register write, after which the write enable is lowered again.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_settings(input logic [8:0] safe_cm, input logic [8:0] slow_cm,
                                    input logic [8:0] clear_cm, input logic [15:0] tmin,
                                    input logic [15:0] tmax, input logic [15:0] bmin,
                                    input logic [15:0] bmax, input logic [3:0] conf);
        write_reg(REG_FRONT_SAFE, {7'd0, safe_cm});
        write_reg(REG_FRONT_SLOW, {7'd0, slow_cm});
        write_reg(REG_BACK_CLEAR, {7'd0, clear_cm});
        write_reg(REG_TURN_MIN, tmin);
        write_reg(REG_TURN_MAX, tmax);
        write_reg(REG_BACK_MIN, bmin);
        write_reg(REG_BACK_MAX, bmax);
        write_reg(REG_CONFIRM, {12'd0, conf});
        aim_safe  = safe_cm;
        aim_slow  = slow_cm;
        aim_clear = clear_cm;
    endtask

    // Stops offering beats and waits until every command is back and the pipe is empty.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random readings grouped into short scenes: corridors, openings on either
    // side, dead ends, open ground and plain noise, so that turns run to their end.
    task automatic run_readings(input int count);
        int         sent;
        int         len;
        int         i;
        t_episode   kind;
        logic       opening_half;
        logic       ok;
        logic       lw;
        logic       rw;
        logic [8:0] reach;
        sent = 0;
        while (sent < count) begin
            kind = t_episode'($urandom_range(5));
            len  = $urandom_range(25, 1);
            for (i = 0; i < len && sent < count; i++) begin
                opening_half = (i < len / 2);
                ok    = ($urandom_range(99) >= 8);
                lw    = 1'b1;
                rw    = 1'($urandom_range(1));
                reach = beyond(aim_safe);
                case (kind)
                    EP_CORRIDOR: begin
                        if ($urandom_range(1))
                            reach = close_to(aim_slow);
                    end
                    EP_LEFT_OPENING: begin
                        lw = !opening_half;
                        if ($urandom_range(1))
                            reach = short_of(aim_safe);
                    end
                    EP_RIGHT_OPENING: begin
                        rw    = !opening_half;
                        reach = opening_half ? short_of(aim_safe) : beyond(aim_safe);
                    end
                    EP_DEAD_END: begin
                        rw = 1'b1;
                        if (opening_half)
                            reach = short_of(aim_safe);
                        else if ($urandom_range(1))
                            reach = beyond(aim_clear);
                        else
                            reach = close_to(aim_clear);
                    end
                    EP_OPEN_FIELD: begin
                        lw = 1'b0;
                        rw = 1'b0;
                        if ($urandom_range(3) == 0)
                            reach = close_to(aim_safe);
                    end
                    default: begin
                        ok = 1'($urandom_range(1));
                        lw = 1'($urandom_range(1));
                        case ($urandom_range(3))
                            0: reach = 9'($urandom_range(511));
                            1: reach = $urandom_range(1) ? 9'd511 : 9'd0;
                            2: reach = close_to(aim_safe);
                            default: reach = close_to(aim_clear);
                        endcase
                    end
                endcase
                send_reading(reach, ok, lw, rw);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_FRONT_SAFE;
        i_cfg_wdata   = 16'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on the reset settings: invalid front, fast and slow
        // forward, and the start of a right turn.
        send_reading(9'd0, 1'b0, 1'b1, 1'b1);
        send_reading(9'd511, 1'b1, 1'b1, 1'b1);
        send_reading(9'd25, 1'b1, 1'b1, 1'b1);
        send_reading(9'd20, 1'b1, 1'b1, 1'b0);
        send_reading(9'd300, 1'b1, 1'b1, 1'b0);
        drain();

        // Short turn times; the run builds up against a high confirm count,
        // which is then lowered under it.
        program_settings(9'd20, 9'd30, 9'd25, 16'd50, 16'd200, 16'd0, 16'd100, 4'd15);
        send_reading(9'd300, 1'b1, 1'b1, 1'b1);
        send_reading(9'd300, 1'b1, 1'b1, 1'b1);
        drain();
        write_reg(REG_CONFIRM, 16'd1);
        send_reading(9'd300, 1'b1, 1'b1, 1'b1);

        // Left turn with a forward creep, then a turn-back spin.
        send_reading(9'd100, 1'b1, 1'b0, 1'b1);
        send_reading(9'd511, 1'b1, 1'b0, 1'b0);
        send_reading(9'd10, 1'b1, 1'b0, 1'b0);
        send_reading(9'd400, 1'b0, 1'b0, 1'b0);
        send_reading(9'd400, 1'b1, 1'b1, 1'b0);
        send_reading(9'd5, 1'b1, 1'b1, 1'b1);
        send_reading(9'd5, 1'b1, 1'b1, 1'b1);
        send_reading(9'd26, 1'b1, 1'b1, 1'b1);
        drain();

        // A confirm count of zero is always met.
        write_reg(REG_CONFIRM, 16'd0);
        write_reg(REG_BACK_MAX, 16'd0);
        send_reading(9'd5, 1'b1, 1'b1, 1'b1);
        send_reading(9'd5, 1'b1, 1'b1, 1'b1);
        drain();

        // Minimum above maximum: the forced end wins.
        write_reg(REG_TURN_MIN, 16'd300);
        write_reg(REG_TURN_MAX, 16'd100);
        write_reg(REG_CONFIRM, 16'd15);
        send_reading(9'd10, 1'b1, 1'b1, 1'b0);
        send_reading(9'd10, 1'b1, 1'b1, 1'b0);
        send_reading(9'd10, 1'b1, 1'b1, 1'b0);
        send_reading(9'd10, 1'b1, 1'b1, 1'b0);
        drain();

        // Random part, first with a slow receiver.
        program_settings(9'd20, 9'd30, 9'd25, 16'd200, 16'd1500, 16'd400, 16'd2500, 4'd3);
        run_readings(160);
        drain();

        // Slow sender; extreme settings.
        tx_idle_pct = 73;
        rx_idle_pct = 12;
        program_settings(9'd0, 9'd511, 9'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 4'd1);
        run_readings(110);
        drain();
        program_settings(9'd511, 9'd0, 9'd511, 16'd65535, 16'd0, 16'd65535, 16'd65535,
                         4'd15);
        run_readings(50);
        drain();

        // No idling; the receiver holds off for a long stretch at the start.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_settings(9'd100, 9'd200, 9'd150, 16'd100, 16'd400, 16'd150, 16'd600, 4'd4);
        fork
            begin
                @(posedge i_clk);
                stall_rx = 1'b1;
                repeat (60) @(posedge i_clk);
                stall_rx = 1'b0;
            end
        join_none
        run_readings(170);
        drain();
        program_settings(9'd300, 9'd100, 9'd50, 16'd0, 16'd75, 16'd0, 16'd75, 4'd15);
        run_readings(70);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
